>>> sv/scts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse column threshold select: shared types and constants
// Beat layouts of the input and result channels, the entry held by each cell,
// the cell control group and the opcode and state encodings.
// ----------------------------------------------------------------------------
package scts_pkg;

    // Field widths fixed by the beat layouts.
    localparam int PROB_W  = 16;
    localparam int STATE_W = 8;
    localparam int RANK_W  = 8;
    localparam int KEY_W   = 8;

    // Rank reported for a rank or state that is not in the column.
    localparam logic [RANK_W-1:0] UNASSIGNED_RANK = 8'd255;

    typedef enum logic [1:0] {
        OP_START      = 2'd0,
        OP_LOAD       = 2'd1,
        OP_READ_RANK  = 2'd2,
        OP_STATE_RANK = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_fsm_state;

    // One input beat.
    typedef struct packed {
        t_opcode             opcode;
        logic [PROB_W-1:0]   posterior;
        logic [KEY_W-1:0]    query_key;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic                hit;
        logic [STATE_W-1:0]  state_number;
        logic [PROB_W-1:0]   entry_prob;
        logic [RANK_W-1:0]   entry_rank;
        logic [RANK_W-1:0]   entry_count;
    } t_out;

    // A kept entry as held in one cell.
    typedef struct packed {
        logic [PROB_W-1:0]   prob;
        logic [STATE_W-1:0]  state;
    } t_entry;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic rotate;
    } t_cell_ctrl;

endpackage

>>> sv/sparse_column_threshold_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse column threshold select
// Builds one sparse profile column from a stream of posteriors and answers
// rank and state queries against it.
// ----------------------------------------------------------------------------
// Start and load beats produce no result. Kept entries sit in a sorted
// chain of MAX_KEEP cells, one rank per cell, and an insertion is placed by
// every cell comparing against the new posterior at the same time. A query
// rotates the whole chain once through cell 0 in ST_SCAN and then passes
// ST_DONE, which waits for the output register, before the next beat is
// taken; on an empty column it goes straight to ST_DONE. Results wait in an
// output register, so loads are accepted while a result is still pending.
// The cutoff register is always ready and must only be written while the
// block is idle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sparse_column_threshold_select #(
    parameter int MAX_KEEP   = 255,
    parameter int MAX_STATES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  scts_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output scts_pkg::t_out                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [scts_pkg::PROB_W-1:0]   i_cfg_data
);

    localparam int CNT_W  = $clog2(MAX_KEEP + 1);
    localparam int SCAN_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int NS_W   = $clog2(MAX_STATES + 1);
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(MAX_KEEP - 1);

    // Control registers.
    scts_pkg::t_fsm_state              r_state, n_state;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic [scts_pkg::PROB_W-1:0]       r_below_prob, n_below_prob;
    logic [scts_pkg::STATE_W-1:0]      r_below_state, n_below_state;
    logic [NS_W-1:0]                   r_next_st, n_next_st;
    logic [scts_pkg::PROB_W-1:0]       r_cutoff;
    logic                              r_out_valid, n_out_valid;

    // Query payload registers.
    scts_pkg::t_opcode                 r_qop, n_qop;
    logic [scts_pkg::KEY_W-1:0]        r_key, n_key;
    logic                              r_found, n_found;
    logic [scts_pkg::STATE_W-1:0]      r_res_state, n_res_state;
    logic [scts_pkg::PROB_W-1:0]       r_res_prob, n_res_prob;
    logic [scts_pkg::RANK_W-1:0]       r_res_rank, n_res_rank;
    logic [SCAN_W-1:0]                 r_scan, n_scan;
    scts_pkg::t_out                    r_out, n_out;

    // Chain signals.
    scts_pkg::t_cell_ctrl              cell_ctrl;
    scts_pkg::t_entry                  new_ent;
    scts_pkg::t_entry                  w_ent  [MAX_KEEP];
    logic                              w_goes [MAX_KEEP];

    // Scan and result helpers.
    logic [SCAN_W-1:0]                 head_rank;
    logic                              head_ok;
    logic                              head_match;
    logic                              empty_hit;
    logic [scts_pkg::RANK_W-1:0]       eff_count;
    logic                              in_acc;

    assign o_in_ready  = (r_state == scts_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    // The entry a load would insert: its posterior and the next state index.
    assign new_ent.prob  = i_in_data.posterior;
    assign new_ent.state = scts_pkg::STATE_W'(r_next_st);

    // Row of cells; cell 0 takes the tail entry when the chain rotates.
    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
        localparam int PREV = (g == 0) ? MAX_KEEP - 1 : g - 1;
        scts_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_count     (r_count),
            .i_new       (new_ent),
            .i_prev      (w_ent[PREV]),
            .i_prev_goes ((g == 0) ? 1'b0 : w_goes[PREV]),
            .o_entry     (w_ent[g]),
            .o_goes      (w_goes[g])
        );
    end

    // Rotation moves every entry one cell up, so after k steps the head cell
    // holds rank MAX_KEEP - k; before the first step it holds rank 0.
    assign head_rank  = (r_scan == '0) ? '0 : SCAN_W'(MAX_KEEP) - r_scan;
    assign head_ok    = (CNT_W'(head_rank) < r_count);
    assign head_match = head_ok &&
                        ((r_qop == scts_pkg::OP_READ_RANK)
                            ? (scts_pkg::KEY_W'(head_rank) == r_key)
                            : (w_ent[0].state == r_key));

    // With nothing kept the best posterior below the cutoff stands at rank 0.
    assign empty_hit = (r_qop == scts_pkg::OP_READ_RANK)
                       ? (r_key == '0)
                       : (r_key == r_below_state);
    assign eff_count = (r_count == '0) ? scts_pkg::RANK_W'(1)
                                       : scts_pkg::RANK_W'(r_count);

    // Next state, beat handling and result assembly.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_below_prob  = r_below_prob;
        n_below_state = r_below_state;
        n_next_st     = r_next_st;
        n_out_valid   = r_out_valid;
        n_qop         = r_qop;
        n_key         = r_key;
        n_found       = r_found;
        n_res_state   = r_res_state;
        n_res_prob    = r_res_prob;
        n_res_rank    = r_res_rank;
        n_scan        = r_scan;
        n_out         = r_out;
        cell_ctrl     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            scts_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.opcode)
                        scts_pkg::OP_START: begin
                            n_count       = '0;
                            n_below_prob  = '0;
                            n_below_state = '0;
                            n_next_st     = '0;
                        end
                        scts_pkg::OP_LOAD: begin
                            if (r_next_st < NS_W'(MAX_STATES)) begin
                                n_next_st = r_next_st + NS_W'(1);
                                if (i_in_data.posterior >= r_cutoff) begin
                                    cell_ctrl.insert = 1'b1;
                                    if (r_count < CNT_W'(MAX_KEEP)) begin
                                        n_count = r_count + CNT_W'(1);
                                    end
                                end else if (i_in_data.posterior > r_below_prob) begin
                                    n_below_prob  = i_in_data.posterior;
                                    n_below_state = new_ent.state;
                                end
                            end
                        end
                        scts_pkg::OP_READ_RANK,
                        scts_pkg::OP_STATE_RANK: begin
                            n_qop   = i_in_data.opcode;
                            n_key   = i_in_data.query_key;
                            n_found = 1'b0;
                            n_scan  = '0;
                            n_state = (r_count == '0) ? scts_pkg::ST_DONE
                                                      : scts_pkg::ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end

            scts_pkg::ST_SCAN: begin
                // Rotate once per cycle, watching the head cell.
                cell_ctrl.rotate = 1'b1;
                if (head_match && !r_found) begin
                    n_found     = 1'b1;
                    n_res_state = w_ent[0].state;
                    n_res_prob  = w_ent[0].prob;
                    n_res_rank  = scts_pkg::RANK_W'(head_rank);
                end
                if (r_scan == SCAN_LAST) begin
                    n_state = scts_pkg::ST_DONE;
                end else begin
                    n_scan = r_scan + SCAN_W'(1);
                end
            end

            scts_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_state               = scts_pkg::ST_IDLE;
                    n_out.entry_count     = eff_count;
                    n_out.hit             = (r_count == '0) ? empty_hit : r_found;
                    n_out.entry_prob      = '0;
                    n_out.entry_rank      = scts_pkg::UNASSIGNED_RANK;
                    n_out.state_number    = (r_qop == scts_pkg::OP_READ_RANK)
                                            ? '0 : r_key;
                    if (n_out.hit) begin
                        if (r_count == '0) begin
                            n_out.entry_prob   = r_below_prob;
                            n_out.entry_rank   = '0;
                            n_out.state_number = r_below_state;
                        end else begin
                            n_out.entry_prob   = r_res_prob;
                            n_out.entry_rank   = r_res_rank;
                            n_out.state_number = r_res_state;
                        end
                    end
                end
            end

            default: begin
                n_state = scts_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= scts_pkg::ST_IDLE;
            r_count       <= '0;
            r_below_prob  <= '0;
            r_below_state <= '0;
            r_next_st     <= '0;
            r_cutoff      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_below_prob  <= n_below_prob;
            r_below_state <= n_below_state;
            r_next_st     <= n_next_st;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cutoff <= i_cfg_data;
            end
        end
    end

    // Query payload and result beat.
    always_ff @(posedge i_clk) begin
        r_qop       <= n_qop;
        r_key       <= n_key;
        r_found     <= n_found;
        r_res_state <= n_res_state;
        r_res_prob  <= n_res_prob;
        r_res_rank  <= n_res_rank;
        r_scan      <= n_scan;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The kept count never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEEP))
        else $error("kept count exceeds chain length");

    // A hit always lies within the column.
    a_hit_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hit) |->
            (o_out_data.entry_rank < o_out_data.entry_count))
        else $error("hit rank outside column");

    // A miss reports the unassigned rank and a zero posterior.
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |->
            (o_out_data.entry_rank == scts_pkg::UNASSIGNED_RANK &&
             o_out_data.entry_prob == '0))
        else $error("miss carries entry data");

    // A passing load into a column with room grows it by one.
    a_load_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.opcode == scts_pkg::OP_LOAD &&
         r_next_st < NS_W'(MAX_STATES) && i_in_data.posterior >= r_cutoff &&
         r_count < CNT_W'(MAX_KEEP)) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("kept count not advanced by load");

    // A query on a non-empty column starts a rotation.
    a_query_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.opcode == scts_pkg::OP_READ_RANK ||
                    i_in_data.opcode == scts_pkg::OP_STATE_RANK) &&
         r_count != '0) |=> (r_state == scts_pkg::ST_SCAN))
        else $error("query did not start a scan");

endmodule

>>> sv/scts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse column threshold select: chain cell
// Holds the entry at one rank. On an insert it either keeps its entry, takes
// the new entry, or takes its left neighbour's entry as the list shifts down.
// On a rotate it takes its left neighbour's entry unconditionally.
// ----------------------------------------------------------------------------
module scts_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic                 i_clk,
    input  scts_pkg::t_cell_ctrl i_ctrl,
    input  logic [CNT_W-1:0]     i_count,
    input  scts_pkg::t_entry     i_new,
    input  scts_pkg::t_entry     i_prev,
    input  logic                 i_prev_goes,
    output scts_pkg::t_entry     o_entry,
    output logic                 o_goes
);

    scts_pkg::t_entry r_entry;

    // The new entry belongs at or above this rank when the slot is empty or
    // holds a strictly smaller posterior; equal posteriors keep their place.
    assign o_goes = i_ctrl.insert &&
                    ((i_count <= CNT_W'(IDX)) || (r_entry.prob < i_new.prob));

    // Shift down below the insertion point, take the new entry at it.
    always_ff @(posedge i_clk) begin
        if (o_goes) begin
            r_entry <= i_prev_goes ? i_prev : i_new;
        end else if (i_ctrl.rotate) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> sim/sparse_column_threshold_select_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse column threshold select: self-checking testbench
// A queue-fed driver offers start, load and query beats to the block while a
// monitor takes its result beats. Every accepted beat updates a local copy of
// the sorted column, and each query adds its answer to a queue of expected
// answers. Result beats are checked against that queue field by field. The
// run steps through several cutoff settings and idling patterns, and holds
// the result channel off once for a long stretch so that the block stalls.
// ----------------------------------------------------------------------------
module sparse_column_threshold_select_test;

    localparam int MAX_KEEP       = 255;
    localparam int MAX_STATES     = 256;
    localparam int SETTLE_CYCLES  = MAX_KEEP + 60;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int PHASE_ITEMS    = 280;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    always #5ns i_clk = ~i_clk;

    // Block inputs, known from time zero.
    logic                          in_valid  = 1'b0;
    scts_pkg::t_in                 in_beat   = '0;
    logic                          out_ready = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [scts_pkg::PROB_W-1:0]   cfg_value = '0;

    logic                          in_ready;
    logic                          out_valid;
    scts_pkg::t_out                out_beat;
    logic                          cfg_ready;

    sparse_column_threshold_select #(
        .MAX_KEEP   (MAX_KEEP),
        .MAX_STATES (MAX_STATES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_value)
    );

    // Stimulus queues, idling controls and bookkeeping.
    scts_pkg::t_in               pending_beats[$];
    logic [scts_pkg::PROB_W-1:0] cutoff_writes[$];
    scts_pkg::t_out              expected_answers[$];
    int                          send_idle_pct  = 0;
    int                          recv_idle_pct  = 0;
    int                          hold_orders    = 0;
    int                          hold_served    = 0;
    int                          hold_left      = 0;
    int                          mismatches     = 0;
    int                          idle_cycles    = 0;
    int                          items_queued   = 0;
    logic [scts_pkg::PROB_W-1:0] phase_cutoff   = '0;

    // Local copy of the column being built.
    logic [scts_pkg::PROB_W-1:0]  model_cutoff = '0;
    logic [scts_pkg::PROB_W-1:0]  col_prob  [MAX_KEEP];
    logic [scts_pkg::STATE_W-1:0] col_state [MAX_KEEP];
    int                           col_count      = 0;
    logic [scts_pkg::PROB_W-1:0]  col_low_prob   = '0;
    logic [scts_pkg::STATE_W-1:0] col_low_state  = '0;
    int                           col_next_state = 0;

    // Place one posterior into the sorted column, or track it as the best
    // posterior below the cutoff.
    function automatic void load_column_posterior(logic [scts_pkg::PROB_W-1:0] p);
        int                           pos;
        int                           last;
        logic [scts_pkg::STATE_W-1:0] st;
        if (col_next_state >= MAX_STATES)
            return;
        st = col_next_state[scts_pkg::STATE_W-1:0];
        col_next_state++;
        if (p >= model_cutoff) begin
            pos = 0;
            while (pos < col_count && col_prob[pos] >= p)
                pos++;
            if (pos >= MAX_KEEP)
                return;
            last = (col_count < MAX_KEEP) ? col_count : MAX_KEEP - 1;
            for (int i = last; i > pos; i--) begin
                col_prob[i]  = col_prob[i-1];
                col_state[i] = col_state[i-1];
            end
            col_prob[pos]  = p;
            col_state[pos] = st;
            if (col_count < MAX_KEEP)
                col_count++;
        end else if (p > col_low_prob) begin
            col_low_prob  = p;
            col_low_state = st;
        end
    endfunction

    // Apply one accepted input beat; queries queue their expected answer.
    function automatic void predict_column_beat(scts_pkg::t_in beat);
        scts_pkg::t_out               ans;
        int                           cnt;
        logic [scts_pkg::STATE_W-1:0] st;
        logic [scts_pkg::PROB_W-1:0]  p;
        case (beat.opcode)
            scts_pkg::OP_START: begin
                col_count      = 0;
                col_low_prob   = '0;
                col_low_state  = '0;
                col_next_state = 0;
            end
            scts_pkg::OP_LOAD: begin
                load_column_posterior(beat.posterior);
            end
            default: begin
                // With nothing kept, the best posterior below the cutoff
                // stands alone at rank zero.
                cnt              = (col_count == 0) ? 1 : col_count;
                ans.hit          = 1'b0;
                ans.state_number = '0;
                ans.entry_prob   = '0;
                ans.entry_rank   = scts_pkg::UNASSIGNED_RANK;
                ans.entry_count  = cnt[scts_pkg::RANK_W-1:0];
                if (beat.opcode == scts_pkg::OP_READ_RANK) begin
                    if (int'(beat.query_key) < cnt) begin
                        ans.hit          = 1'b1;
                        ans.state_number = (col_count == 0) ? col_low_state
                                                            : col_state[beat.query_key];
                        ans.entry_prob   = (col_count == 0) ? col_low_prob
                                                            : col_prob[beat.query_key];
                        ans.entry_rank   = beat.query_key;
                    end
                end else begin
                    ans.state_number = beat.query_key;
                    for (int r = 0; r < cnt; r++) begin
                        st = (col_count == 0) ? col_low_state : col_state[r];
                        p  = (col_count == 0) ? col_low_prob  : col_prob[r];
                        if (st == beat.query_key) begin
                            ans.hit        = 1'b1;
                            ans.entry_prob = p;
                            ans.entry_rank = r[scts_pkg::RANK_W-1:0];
                            break;
                        end
                    end
                end
                expected_answers.insert(expected_answers.size(), ans);
            end
        endcase
    endfunction

    // Input driver: offers queued beats, with random gaps between them.
    always @(posedge i_clk) begin : input_driver
        logic waiting;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            waiting = in_valid && !in_ready;
            if (in_valid && in_ready)
                predict_column_beat(in_beat);
            if (!waiting) begin
                if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_beat  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Cutoff register writes.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready)
                model_cutoff = cfg_value;
            if (!cfg_valid || cfg_ready) begin
                if (cutoff_writes.size() > 0) begin
                    cfg_value <= cutoff_writes.pop_front();
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each taken beat and sets the ready pattern,
    // including the long hold-off when one is ordered.
    always @(posedge i_clk) begin : result_monitor
        scts_pkg::t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_answers.size() == 0) begin
                    $error("result beat with no query outstanding");
                    mismatches++;
                end else begin
                    want = expected_answers.pop_front();
                    if (out_beat.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, out_beat.hit);
                        mismatches++;
                    end
                    if (out_beat.state_number !== want.state_number) begin
                        $error("state_number: expected %0d, got %0d",
                               want.state_number, out_beat.state_number);
                        mismatches++;
                    end
                    if (out_beat.entry_prob !== want.entry_prob) begin
                        $error("entry_prob: expected %0h, got %0h",
                               want.entry_prob, out_beat.entry_prob);
                        mismatches++;
                    end
                    if (out_beat.entry_rank !== want.entry_rank) begin
                        $error("entry_rank: expected %0d, got %0d",
                               want.entry_rank, out_beat.entry_rank);
                        mismatches++;
                    end
                    if (out_beat.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, out_beat.entry_count);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_orders != hold_served) begin
                hold_served <= hold_served + 1;
                hold_left   <= HOLD_CYCLES;
                out_ready   <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: counts cycles in which no channel moves a beat.
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sparse_column_threshold_select verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void push_beat(scts_pkg::t_opcode op,
                                      logic [scts_pkg::PROB_W-1:0] post,
                                      logic [scts_pkg::KEY_W-1:0] key);
        scts_pkg::t_in beat;
        beat.opcode    = op;
        beat.posterior = post;
        beat.query_key = key;
        pending_beats.insert(pending_beats.size(), beat);
        items_queued++;
    endfunction

    // Posteriors lean towards the extremes, the cutoff edge and repeats.
    function automatic logic [scts_pkg::PROB_W-1:0] pick_posterior();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return phase_cutoff;
            3:       return phase_cutoff - 16'd1;
            4:       return ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
            default: return scts_pkg::PROB_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Query keys mostly land on ranks or states that may be present.
    function automatic void push_query(int loads);
        int span;
        span = (loads > 255) ? 255 : loads;
        push_beat(($urandom_range(0, 1) != 0) ? scts_pkg::OP_READ_RANK
                                              : scts_pkg::OP_STATE_RANK,
                  scts_pkg::PROB_W'($urandom_range(0, 65535)),
                  scts_pkg::KEY_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, span)
                                                              : $urandom_range(0, 255)));
    endfunction

    // One column: a start, a run of loads with the odd query among them,
    // then a few queries; now and then some arbitrary beats as noise.
    function automatic void push_column();
        int n_loads;
        n_loads = ($urandom_range(0, 11) == 0) ? $urandom_range(250, 270)
                                               : $urandom_range(0, 24);
        push_beat(scts_pkg::OP_START, scts_pkg::PROB_W'($urandom_range(0, 65535)),
                  scts_pkg::KEY_W'($urandom_range(0, 255)));
        for (int i = 0; i < n_loads; i++) begin
            push_beat(scts_pkg::OP_LOAD, pick_posterior(),
                      scts_pkg::KEY_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0)
                push_query(i + 1);
        end
        repeat ($urandom_range(1, 5))
            push_query(n_loads);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4))
                push_beat(scts_pkg::t_opcode'($urandom_range(0, 3)),
                          scts_pkg::PROB_W'($urandom_range(0, 65535)),
                          scts_pkg::KEY_W'($urandom_range(0, 255)));
        end
    endfunction

    // Wait until every beat is through and every answer has come, then give
    // the block time to finish any query scan still under way.
    task automatic settle();
        @(negedge i_clk);
        while (pending_beats.size() != 0 || in_valid || expected_answers.size() != 0
                || cutoff_writes.size() != 0 || cfg_valid)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cutoff(logic [scts_pkg::PROB_W-1:0] value);
        @(negedge i_clk);
        phase_cutoff = value;
        cutoff_writes.insert(cutoff_writes.size(), value);
        while (cutoff_writes.size() != 0 || cfg_valid)
            @(negedge i_clk);
    endtask

    task automatic random_phase(logic [scts_pkg::PROB_W-1:0] cutoff, int s_idle,
                                int r_idle, bit hold);
        int target;
        write_cutoff(cutoff);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        target = items_queued + PHASE_ITEMS;
        while (items_queued < target)
            push_column();
        if (hold)
            hold_orders++;
        settle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed beats with the cutoff at one half.
        write_cutoff(16'h8000);
        send_idle_pct = 24;
        recv_idle_pct = 86;
        // Empty column after reset: state zero with posterior zero.
        push_beat(scts_pkg::OP_READ_RANK,  16'h0000, 8'd0);
        push_beat(scts_pkg::OP_READ_RANK,  16'hFFFF, 8'd1);
        push_beat(scts_pkg::OP_STATE_RANK, 16'h0000, 8'd0);
        push_beat(scts_pkg::OP_STATE_RANK, 16'hFFFF, 8'd7);
        // Nothing reaches the cutoff; the first of two equal bests stands.
        push_beat(scts_pkg::OP_START, 16'hFFFF, 8'hFF);
        push_beat(scts_pkg::OP_LOAD,  16'h1000, 8'h00);
        push_beat(scts_pkg::OP_LOAD,  16'h7FFF, 8'hFF);
        push_beat(scts_pkg::OP_LOAD,  16'h7FFF, 8'h00);
        push_beat(scts_pkg::OP_LOAD,  16'h2000, 8'hFF);
        push_beat(scts_pkg::OP_READ_RANK,  16'h0000, 8'd0);
        push_beat(scts_pkg::OP_STATE_RANK, 16'h0000, 8'd1);
        push_beat(scts_pkg::OP_STATE_RANK, 16'h0000, 8'd2);
        // Entries at and above the cutoff, with a tie and a zero posterior.
        push_beat(scts_pkg::OP_LOAD,  16'h8000, 8'h00);
        push_beat(scts_pkg::OP_LOAD,  16'hFFFF, 8'h00);
        push_beat(scts_pkg::OP_LOAD,  16'h8000, 8'h00);
        push_beat(scts_pkg::OP_LOAD,  16'h0000, 8'h00);
        push_beat(scts_pkg::OP_READ_RANK,  16'h0000, 8'd0);
        push_beat(scts_pkg::OP_READ_RANK,  16'h0000, 8'd1);
        push_beat(scts_pkg::OP_READ_RANK,  16'h0000, 8'd2);
        push_beat(scts_pkg::OP_READ_RANK,  16'h0000, 8'd3);
        push_beat(scts_pkg::OP_READ_RANK,  16'h0000, 8'd255);
        push_beat(scts_pkg::OP_STATE_RANK, 16'h0000, 8'd6);
        push_beat(scts_pkg::OP_STATE_RANK, 16'h0000, 8'd7);
        push_beat(scts_pkg::OP_STATE_RANK, 16'h0000, 8'd255);
        // A new column forgets everything.
        push_beat(scts_pkg::OP_START, 16'h0000, 8'h00);
        push_beat(scts_pkg::OP_READ_RANK, 16'h0000, 8'd0);
        settle();

        // Random phases over the cutoff extremes and the idling patterns.
        random_phase(16'h0000, 24, 86, 1'b0);
        random_phase(16'hFFFF, 24, 86, 1'b0);
        random_phase(scts_pkg::PROB_W'($urandom_range(0, 65535)), 86, 24, 1'b1);
        random_phase(16'h0001, 86, 24, 1'b0);
        random_phase(scts_pkg::PROB_W'($urandom_range(0, 65535)), 0, 0, 1'b0);
        random_phase(scts_pkg::PROB_W'($urandom_range(0, 65535)), 0, 0, 1'b0);

        if (mismatches == 0)
            $display("sparse_column_threshold_select verification clean");
        else
            $display("sparse_column_threshold_select verification failed");
        $finish;
    end

endmodule
